// ----- rtl/utf8n_pkg.sv -----
// Shared types and constants for the UTF-8 word normalizer.
package utf8n_pkg;

   localparam int MAX_WORD_LEN_DEF = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_REJECTED = 2'd2;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

   typedef enum logic [2:0] {
      CLS_LETTER,
      CLS_MARK,
      CLS_PUNCT,
      CLS_LEAD_E2,
      CLS_LEAD_C2,
      CLS_NONASCII
   } byte_class_type;

   typedef struct packed {
      byte_class_type cls;
      logic [6:0]     ch_lc;
      logic           is_80;
      logic           is_99;
      logic           is_ad;
      logic [1:0]     skip_len;
      logic           last;
   } item_type;

   typedef enum logic [1:0] {
      PH_COLLECT,
      PH_ENDED,
      PH_REJECT
   } phase_type;

   typedef enum logic [1:0] {
      PEND_NONE,
      PEND_E2,
      PEND_E280,
      PEND_C2
   } pend_type;

   typedef enum logic {
      BK_PARSE,
      BK_READ
   } back_state_type;

endpackage

// ----- rtl/utf8_word_normalizer_core.sv -----
// Top level of the UTF-8 word normalizer: front, queue and back.
//
//   channel   dir   handshake             payload
//   req       in    req_valid/req_stall   req_raw_byte, req_end_of_string
//   rsp       out   rsp_valid/rsp_stall   rsp_word_char, rsp_status, rsp_last_char
//
// A byte enters each cycle while the four-entry queue has room; the back end parses
// one queued byte per cycle unless reading out or waiting to emit a final byte.
// A final byte with a bad status gives one result item in the next cycle; a good
// word reads out via the word memory's registered read port and output register.
// Reset is synchronous and clears control state only; the word memory is not cleared.
// rsp_stall holds the output register and then the back end; the queue absorbs
// up to four bytes before req_stall rises.
module utf8_word_normalizer_core #(
   parameter int MAX_WORD_LEN = utf8n_pkg::MAX_WORD_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_raw_byte,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_word_char,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_char
);

   utf8n_pkg::item_type push_item;
   utf8n_pkg::item_type head_item;
   logic                q_push;
   logic                q_pop;
   logic                q_full;
   logic                q_empty;

   utf8n_front u_front (
      .req_valid         (req_valid),
      .req_raw_byte      (req_raw_byte),
      .req_end_of_string (req_end_of_string),
      .q_full            (q_full),
      .req_stall         (req_stall),
      .q_push            (q_push),
      .q_item            (push_item)
   );

   utf8n_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   utf8n_back #(
      .MAX_WORD_LEN (MAX_WORD_LEN)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_item     (head_item),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word_char (rsp_word_char),
      .rsp_status    (rsp_status),
      .rsp_last_char (rsp_last_char)
   );

   // a status item other than ok is a lone item with a zero character
   a_status_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != utf8n_pkg::STATUS_OK |-> rsp_last_char && rsp_word_char == 7'd0)
      else $error("bad status item not a single zero item");

   // only ok items may come without last_char: every character of a word but the final one
   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_char |-> rsp_status == utf8n_pkg::STATUS_OK)
      else $error("non-final item with error status");

   // back end never takes from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");

endmodule

// ----- rtl/utf8n_front.sv -----
// Front end: classifies each raw byte and pushes it into the queue.
module utf8n_front (
   input  logic                  req_valid,
   input  logic [7:0]            req_raw_byte,
   input  logic                  req_end_of_string,
   input  logic                  q_full,
   output logic                  req_stall,
   output logic                  q_push,
   output utf8n_pkg::item_type   q_item
);

   localparam logic [7:0] BYTE_E2   = 8'hE2;
   localparam logic [7:0] BYTE_C2   = 8'hC2;
   localparam logic [7:0] BYTE_80   = 8'h80;
   localparam logic [7:0] BYTE_99   = 8'h99;
   localparam logic [7:0] BYTE_AD   = 8'hAD;
   localparam logic [7:0] BYTE_F0   = 8'hF0;
   localparam logic [7:0] BYTE_E0   = 8'hE0;
   localparam logic [7:0] BYTE_APOS = 8'h27;
   localparam logic [7:0] BYTE_DASH = 8'h2D;

   logic [7:0] b;

   assign b         = req_raw_byte;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_item          = '0;
      q_item.ch_lc    = b[6:0];
      q_item.is_80    = (b == BYTE_80);
      q_item.is_99    = (b == BYTE_99);
      q_item.is_ad    = (b == BYTE_AD);
      q_item.last     = req_end_of_string;
      q_item.cls      = utf8n_pkg::CLS_PUNCT;
      if (b >= BYTE_F0) begin
         q_item.skip_len = 2'd3;
      end else if (b >= BYTE_E0) begin
         q_item.skip_len = 2'd2;
      end else begin
         q_item.skip_len = 2'd1;
      end
      if (!b[7]) begin
         if (b >= 8'h61 && b <= 8'h7A) begin
            q_item.cls = utf8n_pkg::CLS_LETTER;
         end else if (b >= 8'h41 && b <= 8'h5A) begin
            q_item.cls   = utf8n_pkg::CLS_LETTER;
            q_item.ch_lc = b[6:0] | 7'h20;
         end else if (b == BYTE_APOS || b == BYTE_DASH) begin
            q_item.cls = utf8n_pkg::CLS_MARK;
         end else begin
            q_item.cls = utf8n_pkg::CLS_PUNCT;
         end
      end else if (b == BYTE_E2) begin
         q_item.cls = utf8n_pkg::CLS_LEAD_E2;
      end else if (b == BYTE_C2) begin
         q_item.cls = utf8n_pkg::CLS_LEAD_C2;
      end else begin
         q_item.cls = utf8n_pkg::CLS_NONASCII;
      end
   end

endmodule

// ----- rtl/utf8n_queue.sv -----
// Small queue of classified items between front and back.
module utf8n_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  utf8n_pkg::item_type   push_item,
   input  logic                  pop,
   output utf8n_pkg::item_type   head_item,
   output logic                  full,
   output logic                  empty
);

   utf8n_pkg::item_type               entries_ff [utf8n_pkg::QUEUE_DEPTH];
   logic [utf8n_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [utf8n_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [utf8n_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full      = (count_ff == utf8n_pkg::QCNT_W'(utf8n_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/utf8n_back.sv -----
// Back end: word parser, word memory and result read-out.
module utf8n_back #(
   parameter int MAX_WORD_LEN = utf8n_pkg::MAX_WORD_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  utf8n_pkg::item_type   head_item,
   input  logic                  q_empty,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [6:0]            rsp_word_char,
   output logic [1:0]            rsp_status,
   output logic                  rsp_last_char
);

   localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
   localparam int ADDR_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
   localparam logic [6:0] CHAR_APOS = 7'h27;

   utf8n_pkg::back_state_type state_ff, state_in;
   utf8n_pkg::phase_type      phase_ff, phase_in;
   utf8n_pkg::pend_type       pend_ff, pend_in;
   logic [1:0]                skip_ff, skip_in;
   logic [LEN_W-1:0]          wlen_ff, wlen_in;
   logic [LEN_W-1:0]          tlen_ff, tlen_in;
   logic                      ovf_ff, ovf_in;
   logic [ADDR_W-1:0]         rd_ff, rd_in;
   logic                      data_ok_ff, data_ok_in;

   logic [6:0]                word_store_ff [MAX_WORD_LEN];
   logic [6:0]                mem_q_ff;

   logic                      out_valid_ff, out_valid_in;
   logic [6:0]                out_char_ff, out_char_in;
   logic [1:0]                out_status_ff, out_status_in;
   logic                      out_last_ff, out_last_in;

   logic                      out_free;
   logic                      started;
   logic                      full_word;
   logic                      wr_en;
   logic [6:0]                wr_char;
   logic [1:0]                status;
   logic                      read_last;

   assign rsp_valid     = out_valid_ff;
   assign rsp_word_char = out_char_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_last_char = out_last_ff;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign started   = (wlen_ff != '0);
   assign full_word = (wlen_ff >= LEN_W'(MAX_WORD_LEN));
   assign read_last = ((LEN_W'(rd_ff) + LEN_W'(1)) == tlen_ff);
   assign q_pop     = (state_ff == utf8n_pkg::BK_PARSE) && !q_empty
                      && (!head_item.last || out_free);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      pend_in       = pend_ff;
      skip_in       = skip_ff;
      wlen_in       = wlen_ff;
      tlen_in       = tlen_ff;
      ovf_in        = ovf_ff;
      rd_in         = rd_ff;
      data_ok_in    = data_ok_ff;
      wr_en         = 1'b0;
      wr_char       = head_item.ch_lc;
      status        = utf8n_pkg::STATUS_OK;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_char_in   = out_char_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;

      unique case (state_ff)
         utf8n_pkg::BK_PARSE: begin
            if (q_pop) begin
               if (phase_ff == utf8n_pkg::PH_COLLECT) begin
                  if (skip_ff != 2'd0) begin
                     skip_in = skip_ff - 2'd1;
                  end else begin
                     unique case (pend_ff)
                        utf8n_pkg::PEND_E2: begin
                           if (head_item.is_80) begin
                              pend_in = utf8n_pkg::PEND_E280;
                           end else begin
                              pend_in = utf8n_pkg::PEND_NONE;
                              if (started) begin
                                 phase_in = utf8n_pkg::PH_REJECT;
                              end else begin
                                 skip_in = 2'd1;
                              end
                           end
                        end
                        utf8n_pkg::PEND_E280: begin
                           pend_in = utf8n_pkg::PEND_NONE;
                           if (head_item.is_99 && started) begin
                              wr_char = CHAR_APOS;
                              if (!full_word) begin
                                 wr_en   = 1'b1;
                                 wlen_in = wlen_ff + LEN_W'(1);
                              end
                           end else if (started) begin
                              phase_in = utf8n_pkg::PH_ENDED;
                           end
                        end
                        utf8n_pkg::PEND_C2: begin
                           pend_in = utf8n_pkg::PEND_NONE;
                           if (!head_item.is_ad && started) begin
                              phase_in = utf8n_pkg::PH_REJECT;
                           end
                        end
                        utf8n_pkg::PEND_NONE: begin
                           unique case (head_item.cls)
                              utf8n_pkg::CLS_LETTER: begin
                                 if (full_word) begin
                                    ovf_in = 1'b1;
                                 end else begin
                                    wr_en   = 1'b1;
                                    wlen_in = wlen_ff + LEN_W'(1);
                                    tlen_in = wlen_ff + LEN_W'(1);
                                 end
                              end
                              utf8n_pkg::CLS_MARK: begin
                                 // drop a mark that does not fit: trimming removes it anyway
                                 if (started && !full_word) begin
                                    wr_en   = 1'b1;
                                    wlen_in = wlen_ff + LEN_W'(1);
                                 end
                              end
                              utf8n_pkg::CLS_PUNCT: begin
                                 if (started) begin
                                    phase_in = utf8n_pkg::PH_ENDED;
                                 end
                              end
                              utf8n_pkg::CLS_LEAD_E2: begin
                                 pend_in = utf8n_pkg::PEND_E2;
                              end
                              utf8n_pkg::CLS_LEAD_C2: begin
                                 pend_in = utf8n_pkg::PEND_C2;
                              end
                              default: begin
                                 if (started) begin
                                    phase_in = utf8n_pkg::PH_REJECT;
                                 end else begin
                                    skip_in = head_item.skip_len;
                                 end
                              end
                           endcase
                        end
                        default: begin
                           pend_in = utf8n_pkg::PEND_NONE;
                        end
                     endcase
                  end
               end

               if (head_item.last) begin
                  // an open sequence at the end counts as a lone non-ASCII char
                  if (phase_in == utf8n_pkg::PH_COLLECT && pend_in != utf8n_pkg::PEND_NONE
                      && wlen_in != '0) begin
                     phase_in = utf8n_pkg::PH_REJECT;
                  end
                  if (phase_in == utf8n_pkg::PH_REJECT) begin
                     status = utf8n_pkg::STATUS_REJECTED;
                  end else if (ovf_in) begin
                     status = utf8n_pkg::STATUS_TOO_LONG;
                  end else if (tlen_in == '0) begin
                     status = utf8n_pkg::STATUS_EMPTY;
                  end else begin
                     status = utf8n_pkg::STATUS_OK;
                  end

                  if (status != utf8n_pkg::STATUS_OK) begin
                     out_valid_in  = 1'b1;
                     out_char_in   = 7'd0;
                     out_status_in = status;
                     out_last_in   = 1'b1;
                     phase_in      = utf8n_pkg::PH_COLLECT;
                     pend_in       = utf8n_pkg::PEND_NONE;
                     skip_in       = 2'd0;
                     wlen_in       = '0;
                     tlen_in       = '0;
                     ovf_in        = 1'b0;
                  end else begin
                     state_in   = utf8n_pkg::BK_READ;
                     rd_in      = '0;
                     data_ok_in = 1'b0;
                  end
               end
            end
         end
         utf8n_pkg::BK_READ: begin
            if (!data_ok_ff) begin
               data_ok_in = 1'b1;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_char_in   = mem_q_ff;
               out_status_in = utf8n_pkg::STATUS_OK;
               out_last_in   = read_last;
               rd_in         = rd_ff + 1'b1;
               data_ok_in    = 1'b0;
               if (read_last) begin
                  state_in = utf8n_pkg::BK_PARSE;
                  rd_in    = '0;
                  phase_in = utf8n_pkg::PH_COLLECT;
                  pend_in  = utf8n_pkg::PEND_NONE;
                  skip_in  = 2'd0;
                  wlen_in  = '0;
                  tlen_in  = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = utf8n_pkg::BK_PARSE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= utf8n_pkg::BK_PARSE;
         phase_ff     <= utf8n_pkg::PH_COLLECT;
         pend_ff      <= utf8n_pkg::PEND_NONE;
         skip_ff      <= 2'd0;
         wlen_ff      <= '0;
         tlen_ff      <= '0;
         ovf_ff       <= 1'b0;
         rd_ff        <= '0;
         data_ok_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         skip_ff      <= skip_in;
         wlen_ff      <= wlen_in;
         tlen_ff      <= tlen_in;
         ovf_ff       <= ovf_in;
         rd_ff        <= rd_in;
         data_ok_ff   <= data_ok_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff   <= out_char_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   // word memory: one write port at the fill point, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_store_ff[wlen_ff[ADDR_W-1:0]] <= wr_char;
      end
      mem_q_ff <= word_store_ff[rd_ff];
   end

endmodule
